// File: rtl/trsc_pkg.sv
// Shared constants, types and helpers for the three-rotor substitution cipher.
`default_nettype none
package trsc_pkg;

	localparam int ALPHABET_SIZE = 26;
	localparam int NUM_ROTORS    = 3;

	localparam int CODE_W = 5;
	localparam int SUM_W  = CODE_W + 1;
	localparam int ADDR_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int SEL_W  = 2;
	localparam int CHAR_W = 8;

	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;

	localparam logic [SEL_W-1:0] SEL_ROTOR0 = 2'd0;
	localparam logic [SEL_W-1:0] SEL_ROTOR1 = 2'd1;
	localparam logic [SEL_W-1:0] SEL_ROTOR2 = 2'd2;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_CHAR = 1'b1
	} cmd_t;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic              ld;
		logic [SEL_W-1:0]  sel;
		addr_t             idx;
		code_t             val;
		logic              chr;
		logic              letter;
		logic              upper;
		logic [CHAR_W-1:0] ch;
		code_t             off1;
		code_t             off2;
	} stage_t;

	typedef struct packed {
		code_t off0;
		code_t off1;
		code_t off2;
	} offsets_t;

	function automatic code_t mod_alpha(input logic [SUM_W-1:0] v);
		code_t r;
		r = '0;
		for (int i = 0; i < 2**SUM_W; i++) begin
			if (v == SUM_W'(i))
				r = CODE_W'(i % ALPHABET_SIZE);
		end
		return r;
	endfunction

	function automatic addr_t rotor_addr(input code_t code, input code_t off);
		code_t r;
		r = mod_alpha(SUM_W'(mod_alpha(SUM_W'(code))) + SUM_W'(off));
		return r[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/three_rotor_substitution_cipher_core.sv
// Top level of the three-rotor substitution cipher core.
//
//  channel  direction  handshake            payload
//  in       to core    in_valid / in_ready  cmd, rotor_select, entry_index,
//                                           entry_value, char_in
//  out      from core  out_valid/out_ready  char_out
//
// One item per cycle sustained. A character goes through three stages, one per
// rotor RAM read, then an output register that drives out_valid.
// Loads travel the same stages and write rotor k in stage k, so reads and writes of
// each table stay in transfer order. Loads give no result.
// Reset clears the offsets and the stage valids; table contents are undefined.
// The pipe stalls only when a character reaches the last stage while out is held.
`default_nettype none
module three_rotor_substitution_cipher_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          cmd,
	input  wire logic [trsc_pkg::SEL_W-1:0]    rotor_select,
	input  wire logic [4:0]                    entry_index,
	input  wire logic [trsc_pkg::CODE_W-1:0]   entry_value,
	input  wire logic [trsc_pkg::CHAR_W-1:0]   char_in,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [trsc_pkg::CHAR_W-1:0]        char_out
);
	import trsc_pkg::*;

	logic        adv;
	logic        in_xfer;
	logic        upper_in, lower_in, ld_ok;
	logic [CHAR_W-1:0] lcode;
	stage_t      st_s0;
	addr_t       addr0, addr1, addr2;
	code_t       rd0, rd1, rd2;
	offsets_t    offs;

	stage_t      st_s1, st_s2, st_s3;
	logic        v_s1, v_s2, v_s3;
	logic        out_valid_q;
	logic [CHAR_W-1:0] char_q;
	code_t       code_fin;
	logic [CHAR_W-1:0] char_fin;

	assign adv      = !(v_s3 && st_s3.chr && out_valid_q && !out_ready);
	assign in_ready = adv;
	assign in_xfer  = in_valid && in_ready;

	// stage 0: decode, rotor 0 address
	always_comb begin
		upper_in = (char_in >= CHAR_UPPER_A) && (char_in <= CHAR_UPPER_Z);
		lower_in = (char_in >= CHAR_LOWER_A) && (char_in <= CHAR_LOWER_Z);
		lcode    = upper_in ? (char_in - CHAR_UPPER_A) : (char_in - CHAR_LOWER_A);
		ld_ok    = (cmd == CMD_LOAD) && (rotor_select < SEL_W'(NUM_ROTORS))
			&& (entry_index < 5'(ALPHABET_SIZE));
		st_s0.ld     = ld_ok;
		st_s0.sel    = rotor_select;
		st_s0.idx    = entry_index[ADDR_W-1:0];
		st_s0.val    = entry_value;
		st_s0.chr    = (cmd == CMD_CHAR);
		st_s0.letter = upper_in || lower_in;
		st_s0.upper  = upper_in;
		st_s0.ch     = char_in;
		st_s0.off1   = offs.off1;
		st_s0.off2   = offs.off2;
		addr0 = rotor_addr(mod_alpha(lcode[SUM_W-1:0]), offs.off0);
	end

	trsc_odometer u_odo (
		.clk   (clk),
		.arst_n(arst_n),
		.clr   (in_xfer && ld_ok),
		.step  (in_xfer && (cmd == CMD_CHAR) && (upper_in || lower_in)),
		.offs  (offs)
	);

	trsc_rotor_ram u_rot0 (
		.clk  (clk),
		.en   (adv),
		.we   (in_xfer && ld_ok && (rotor_select == SEL_ROTOR0)),
		.waddr(st_s0.idx),
		.wdata(st_s0.val),
		.raddr(addr0),
		.rdata(rd0)
	);

	assign addr1 = rotor_addr(rd0, st_s1.off1);

	trsc_rotor_ram u_rot1 (
		.clk  (clk),
		.en   (adv),
		.we   (adv && v_s1 && st_s1.ld && (st_s1.sel == SEL_ROTOR1)),
		.waddr(st_s1.idx),
		.wdata(st_s1.val),
		.raddr(addr1),
		.rdata(rd1)
	);

	assign addr2 = rotor_addr(rd1, st_s2.off2);

	trsc_rotor_ram u_rot2 (
		.clk  (clk),
		.en   (adv),
		.we   (adv && v_s2 && st_s2.ld && (st_s2.sel == SEL_ROTOR2)),
		.waddr(st_s2.idx),
		.wdata(st_s2.val),
		.raddr(addr2),
		.rdata(rd2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_xfer && (ld_ok || (cmd == CMD_CHAR));
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= st_s0;
			st_s2 <= st_s1;
			st_s3 <= st_s2;
		end
	end

	// stage 3: final letter
	always_comb begin
		code_fin = mod_alpha(SUM_W'(rd2));
		if (st_s3.letter)
			char_fin = (st_s3.upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(code_fin);
		else
			char_fin = st_s3.ch;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_s3 && st_s3.chr && adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && st_s3.chr && adv)
			char_q <= char_fin;
	end

	assign out_valid = out_valid_q;
	assign char_out  = char_q;

	a_offs_range: assert property (@(posedge clk) disable iff (!arst_n)
		(offs.off0 < CODE_W'(ALPHABET_SIZE)) && (offs.off1 < CODE_W'(ALPHABET_SIZE))
		&& (offs.off2 < CODE_W'(ALPHABET_SIZE)))
		else $error("rotor offset out of range");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && ld_ok) |=> (offs == '0))
		else $error("table load did not clear offsets");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && st_s3.chr && out_valid && !out_ready) |-> !in_ready)
		else $error("transfer taken while last stage is blocked");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("pending result dropped");

endmodule
`default_nettype wire

// File: rtl/trsc_rotor_ram.sv
// One rotor table: synchronous RAM, one write and one registered read port.
`default_nettype none
module trsc_rotor_ram (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic            we,
	input  wire trsc_pkg::addr_t waddr,
	input  wire trsc_pkg::code_t wdata,
	input  wire trsc_pkg::addr_t raddr,
	output trsc_pkg::code_t      rdata
);
	import trsc_pkg::*;

	code_t mem [ALPHABET_SIZE];
	code_t rdata_q;

	// read-first: a same-cycle write to raddr is seen by the next read only
	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem[waddr] <= wdata;
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: rtl/trsc_odometer.sv
// Rotor offset counters, stepped like an odometer and cleared by table loads.
`default_nettype none
module trsc_odometer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           clr,
	input  wire logic           step,
	output trsc_pkg::offsets_t  offs
);
	import trsc_pkg::*;

	localparam code_t LAST = CODE_W'(ALPHABET_SIZE - 1);

	offsets_t offs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offs_q <= '0;
		end else if (clr) begin
			offs_q <= '0;
		end else if (step) begin
			if (offs_q.off0 >= LAST) begin
				offs_q.off0 <= '0;
				if (offs_q.off1 >= LAST) begin
					offs_q.off1 <= '0;
					if (offs_q.off2 >= LAST)
						offs_q.off2 <= '0;
					else
						offs_q.off2 <= offs_q.off2 + 1'b1;
				end else begin
					offs_q.off1 <= offs_q.off1 + 1'b1;
				end
			end else begin
				offs_q.off0 <= offs_q.off0 + 1'b1;
			end
		end
	end

	assign offs = offs_q;

endmodule
`default_nettype wire

// File: tb/sv/tb_three_rotor_substitution_cipher_core.sv
// Testbench for the three-rotor substitution cipher core: predicts each character and checks it.
module tb_three_rotor_substitution_cipher_core;
	import trsc_pkg::*;

	localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;
	localparam int TABLE_DEPTH = NUM_ROTORS * ALPHABET_SIZE;
	localparam int ODOMETER_LEN = ALPHABET_SIZE * ALPHABET_SIZE + 40;
	localparam int RANDOM_ITEMS = 700;
	localparam int CALM_TAIL = 300;
	localparam int HOLDOFF_AT = 500;
	localparam int HOLDOFF_LEN = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		cmd_t              cmd;
		logic [SEL_W-1:0]  sel;
		logic [4:0]        idx;
		code_t             val;
		logic [CHAR_W-1:0] ch;
	} cipher_xfer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	cmd_t cmd = CMD_LOAD;
	logic [SEL_W-1:0] rotor_select = '0;
	logic [4:0] entry_index = '0;
	code_t entry_value = '0;
	logic [CHAR_W-1:0] char_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CHAR_W-1:0] char_out;

	cipher_xfer_t pending_xfers[$];
	cipher_xfer_t driven_xfer;
	logic [CHAR_W-1:0] expected_chars[$];
	code_t rotor_mem [0:TABLE_DEPTH-1];
	int rotor_pos [NUM_ROTORS];
	int errors = 0;
	int gap_left, gap_pct, stall_left, stall_pct;
	int results_seen, holdoff_left, quiet_cycles;
	logic holdoff_done;

	three_rotor_substitution_cipher_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.rotor_select (rotor_select),
		.entry_index  (entry_index),
		.entry_value  (entry_value),
		.char_in      (char_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_out     (char_out)
	);

	always #5 clk = ~clk;

	function automatic void encipher_predict(input cipher_xfer_t x);
		int base;
		int c;
		int r;
		logic carry;
		if (x.cmd == CMD_LOAD) begin
			if (x.sel < NUM_ROTORS && x.idx < ALPHABET_SIZE) begin
				rotor_mem[x.sel * ALPHABET_SIZE + x.idx] = x.val;
				for (r = 0; r < NUM_ROTORS; r++)
					rotor_pos[r] = 0;
			end
			return;
		end
		if (x.ch >= CHAR_UPPER_A && x.ch <= CHAR_UPPER_Z)
			base = CHAR_UPPER_A;
		else if (x.ch >= CHAR_LOWER_A && x.ch <= CHAR_LOWER_Z)
			base = CHAR_LOWER_A;
		else begin
			expected_chars.push_back(x.ch);
			return;
		end
		c = (x.ch - base) % ALPHABET_SIZE;
		for (r = 0; r < NUM_ROTORS; r++)
			c = rotor_mem[r * ALPHABET_SIZE + (c + rotor_pos[r]) % ALPHABET_SIZE]
				% ALPHABET_SIZE;
		expected_chars.push_back(CHAR_W'(base + c));
		// odometer step
		carry = 1'b1;
		for (r = 0; r < NUM_ROTORS; r++) begin
			if (carry) begin
				rotor_pos[r] = rotor_pos[r] + 1;
				carry = (rotor_pos[r] >= ALPHABET_SIZE);
				if (carry)
					rotor_pos[r] = 0;
			end
		end
	endfunction

	task automatic push_load(input logic [SEL_W-1:0] sel, input logic [4:0] idx,
			input code_t val);
		cipher_xfer_t x;
		x.cmd = CMD_LOAD;
		x.sel = sel;
		x.idx = idx;
		x.val = val;
		x.ch = CHAR_W'($urandom_range(255));
		pending_xfers.push_back(x);
	endtask

	task automatic push_char(input logic [CHAR_W-1:0] ch);
		cipher_xfer_t x;
		x.cmd = CMD_CHAR;
		x.sel = SEL_W'($urandom_range(3));
		x.idx = 5'($urandom_range(31));
		x.val = CODE_W'($urandom_range(31));
		x.ch = ch;
		pending_xfers.push_back(x);
	endtask

	task automatic push_rotor_permutation(input logic [SEL_W-1:0] sel);
		int perm [ALPHABET_SIZE];
		int i, j, t;
		for (i = 0; i < ALPHABET_SIZE; i++)
			perm[i] = i;
		for (i = ALPHABET_SIZE - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (i = 0; i < ALPHABET_SIZE; i++)
			push_load(sel, 5'(i), CODE_W'(perm[i]));
	endtask

	function automatic logic [CHAR_W-1:0] random_letter();
		if ($urandom_range(1))
			return CHAR_W'(CHAR_UPPER_A + $urandom_range(ALPHABET_SIZE - 1));
		return CHAR_W'(CHAR_LOWER_A + $urandom_range(ALPHABET_SIZE - 1));
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin : drive_in
		cipher_xfer_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
			gap_pct <= 0;
		end else begin
			if (in_valid && in_ready)
				encipher_predict(driven_xfer);
			if ($urandom_range(199) == 0)
				gap_pct <= ($urandom_range(2) == 0) ? 0 : $urandom_range(40);
			if (in_valid && !in_ready) begin
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_xfers.size() == 0) begin
				in_valid <= 1'b0;
			end else if (pending_xfers.size() >= CALM_TAIL
					&& $urandom_range(99) < gap_pct) begin
				gap_left <= $urandom_range(10);
				in_valid <= 1'b0;
			end else begin
				nxt = pending_xfers.pop_front();
				driven_xfer <= nxt;
				cmd <= nxt.cmd;
				rotor_select <= nxt.sel;
				entry_index <= nxt.idx;
				entry_value <= nxt.val;
				char_in <= nxt.ch;
				in_valid <= 1'b1;
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : check_out
		logic [CHAR_W-1:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			stall_pct <= 0;
			results_seen <= 0;
			holdoff_left <= 0;
			holdoff_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_chars.size() == 0) begin
					$error("char_out: no result expected, actual %h", char_out);
					errors++;
				end else begin
					want = expected_chars.pop_front();
					if (char_out !== want) begin
						$error("char_out mismatch: expected %h actual %h", want, char_out);
						errors++;
					end
				end
			end
			if ($urandom_range(199) == 0)
				stall_pct <= ($urandom_range(2) == 0) ? 0 : $urandom_range(40);
			if (holdoff_left > 0) begin
				holdoff_left <= holdoff_left - 1;
				out_ready <= 1'b0;
			end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
				holdoff_done <= 1'b1;
				holdoff_left <= HOLDOFF_LEN;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (pending_xfers.size() >= CALM_TAIL
					&& $urandom_range(99) < stall_pct) begin
				stall_left <= $urandom_range(10);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int n;
		int r;

		// non-letters and ignored loads, safe before the tables hold anything
		push_char(8'h00);
		push_char(8'hFF);
		push_char(CHAR_W'(CHAR_UPPER_A - 1));
		push_char(CHAR_W'(CHAR_UPPER_Z + 1));
		push_char(CHAR_W'(CHAR_LOWER_A - 1));
		push_char(CHAR_W'(CHAR_LOWER_Z + 1));
		push_load(SEL_NONE, 5'd0, 5'd7);
		push_load(SEL_ROTOR1, 5'd26, 5'd3);
		push_load(SEL_ROTOR2, 5'd31, 5'd31);

		push_rotor_permutation(SEL_ROTOR0);
		push_rotor_permutation(SEL_ROTOR1);
		push_rotor_permutation(SEL_ROTOR2);

		push_char(CHAR_UPPER_A);
		push_char(CHAR_UPPER_Z);
		push_char(CHAR_LOWER_A);
		push_char(CHAR_LOWER_Z);
		// out-of-range entry values wrap when used
		push_load(SEL_ROTOR0, 5'd0, 5'd31);
		push_load(SEL_ROTOR1, 5'd5, 5'd26);
		push_load(SEL_ROTOR2, 5'd25, 5'd30);
		push_char(CHAR_UPPER_A);
		push_char(CHAR_LOWER_A);
		push_char(CHAR_LOWER_Z);
		push_char(CHAR_UPPER_Z);
		push_char(8'h20);
		push_char(CHAR_W'(CHAR_LOWER_A + 5));

		// long letter run so the first two offsets wrap and the third steps
		for (n = 0; n < ODOMETER_LEN; n++) begin
			push_char(random_letter());
			if ($urandom_range(63) == 0)
				push_char(8'h30 + CHAR_W'($urandom_range(9)));
		end

		n = 0;
		while (n < RANDOM_ITEMS) begin
			r = $urandom_range(99);
			if (r < 3) begin
				push_rotor_permutation(SEL_W'($urandom_range(NUM_ROTORS - 1)));
				n += ALPHABET_SIZE;
			end else if (r < 10) begin
				push_load(SEL_W'($urandom_range(3)), 5'($urandom_range(31)),
					CODE_W'($urandom_range(31)));
				n++;
			end else if (r < 75) begin
				push_char(random_letter());
				n++;
			end else begin
				push_char(CHAR_W'($urandom_range(255)));
				n++;
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_xfers.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
